FILE: sv/indexed_list_store_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the indexed list store
// Shared wrappers for concurrent checks, clocked on the rising edge and
// switched off while the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_STORE_MACROS_SVH
`define INDEXED_LIST_STORE_MACROS_SVH

// Same-cycle implication.
`define ILS_ASSERT_NOW(label, clk_s, rstn_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ILS_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/ils_pkg.sv
// ----------------------------------------------------------------------------
// Indexed list store package
// Operation codes, status codes and fixed port widths of the list store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ils_pkg;

	// Widths of the transaction fields, fixed by the interface.
	localparam int OPCODE_W = 3;
	localparam int POS_W    = 10;
	localparam int VALUE_W  = 64;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;

	typedef enum logic [OPCODE_W-1:0] {
		OP_GET    = 3'd0,
		OP_SET    = 3'd1,
		OP_INSERT = 3'd2,
		OP_APPEND = 3'd3,
		OP_POP    = 3'd4,
		OP_CLEAR  = 3'd5
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_INDEX = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

endpackage

FILE: sv/indexed_list_store.sv
// ----------------------------------------------------------------------------
// Indexed list store
// Bounded list of values in one synchronous memory, addressed by position with
// negative positions counting back from the end.
// ----------------------------------------------------------------------------
// The list holds up to CAPACITY values of VALUE_WIDTH bits in a single memory
// with one write port and one registered read port, plus a count of entries in
// use. Each input transaction yields exactly one result transaction. Insert
// and pop move the entries behind the position one place per cycle through the
// memory port, so their cost grows with the number of entries moved. The next
// transaction is accepted once the current one is finished; a finished result
// sits in the output register and does not hold up the next input. There is no
// clearing pass after reset: the count alone decides which entries can be read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "indexed_list_store_macros.svh"

module indexed_list_store
	import ils_pkg::*;
#(
	parameter int CAPACITY    = 256,
	parameter int VALUE_WIDTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,

	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [OPCODE_W-1:0]        opcode,
	input  logic signed [POS_W-1:0]    position,
	input  logic [VALUE_W-1:0]         value,

	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [VALUE_W-1:0]         read_value,
	output logic [STATUS_W-1:0]        status,
	output logic [COUNT_W-1:0]         entry_count
);

	// Count needs to hold CAPACITY itself; an address needs only CAPACITY-1.
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	// Width for resolving positions: room for the count, the sign, and a carry.
	localparam int RW = ((CW > POS_W) ? CW : POS_W) + 2;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_WALK  = 5'b00010,
		S_DRAIN = 5'b00100,
		S_PUT   = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

	state_t                 state_q;
	logic [CW-1:0]          count_q;
	logic [STATUS_W-1:0]    st_q;
	logic                   ins_q;
	logic                   up_q;
	logic                   first_q;
	logic [AW-1:0]          cur_q;
	logic [AW-1:0]          end_q;
	logic [AW-1:0]          pos_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic [VALUE_WIDTH-1:0] rv_q;

	// Memory read stage.
	logic                   pend_s1;
	logic                   cap_s1;
	logic [AW-1:0]          wa_s1;
	logic [VALUE_WIDTH-1:0] rdata_s1;

	logic [VALUE_WIDTH-1:0] mem [CAPACITY];

	logic                   mem_we;
	logic [AW-1:0]          mem_wa;
	logic [VALUE_WIDTH-1:0] mem_wd;

	logic [RW-1:0]          pos_sx;
	logic [RW-1:0]          pos_res;
	logic [RW-1:0]          limit;
	logic                   idx_ok;
	logic                   full;
	logic [AW-1:0]          pos_a;
	logic [AW-1:0]          last_a;
	logic                   accept;
	logic                   resp_go;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign resp_go  = (state_q == S_RESP) && (!out_valid || out_ready);

	// Resolve the position against the current count. A negative position has
	// the count added; insert may also address the slot just past the end.
	always_comb begin
		pos_sx  = {{(RW - POS_W){position[POS_W-1]}}, position};
		pos_res = position[POS_W-1] ? (pos_sx + RW'(count_q)) : pos_sx;
		limit   = (opcode == OP_INSERT) ? (RW'(count_q) + RW'(1)) : RW'(count_q);
		idx_ok  = !pos_res[RW-1] && (pos_res < limit);
		full    = (count_q == CW'(CAPACITY));
		pos_a   = pos_res[AW-1:0];
		last_a  = AW'(count_q - CW'(1));
	end

	// A pending shifted entry takes the write port; the new value of set,
	// insert and append goes in only once the shifting has drained.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = wa_s1;
		mem_wd = rdata_s1;
		if (pend_s1 && !cap_s1) begin
			mem_we = 1'b1;
		end else if (state_q == S_PUT) begin
			mem_we = 1'b1;
			mem_wa = pos_q;
			mem_wd = value_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (state_q == S_WALK) begin
			rdata_s1 <= mem[cur_q];
		end
	end

	// Control: sequencer, count and the read stage pending flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			st_q      <= ST_OK;
			ins_q     <= 1'b0;
			up_q      <= 1'b0;
			first_q   <= 1'b0;
			pend_s1   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			pend_s1 <= (state_q == S_WALK);
			if (resp_go) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						ins_q   <= (opcode == OP_INSERT);
						up_q    <= (opcode != OP_INSERT);
						first_q <= (opcode != OP_INSERT);
						case (opcode)
							OP_GET: begin
								if (idx_ok) begin
									st_q    <= ST_OK;
									state_q <= S_WALK;
								end else begin
									st_q    <= ST_INDEX;
									state_q <= S_RESP;
								end
							end
							OP_SET: begin
								if (idx_ok) begin
									st_q    <= ST_OK;
									state_q <= S_PUT;
								end else begin
									st_q    <= ST_INDEX;
									state_q <= S_RESP;
								end
							end
							OP_INSERT: begin
								if (!idx_ok) begin
									st_q    <= ST_INDEX;
									state_q <= S_RESP;
								end else if (full) begin
									st_q    <= ST_FULL;
									state_q <= S_RESP;
								end else begin
									st_q    <= ST_OK;
									count_q <= count_q + CW'(1);
									state_q <= (pos_res == RW'(count_q)) ? S_PUT : S_WALK;
								end
							end
							OP_APPEND: begin
								if (full) begin
									st_q    <= ST_FULL;
									state_q <= S_RESP;
								end else begin
									st_q    <= ST_OK;
									count_q <= count_q + CW'(1);
									state_q <= S_PUT;
								end
							end
							OP_POP: begin
								if (idx_ok) begin
									st_q    <= ST_OK;
									count_q <= count_q - CW'(1);
									state_q <= S_WALK;
								end else begin
									st_q    <= ST_INDEX;
									state_q <= S_RESP;
								end
							end
							OP_CLEAR: begin
								st_q    <= ST_OK;
								count_q <= '0;
								state_q <= S_RESP;
							end
							default: begin
								st_q    <= ST_OK;
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_WALK: begin
					first_q <= 1'b0;
					if (cur_q == end_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= ins_q ? S_PUT : S_RESP;
				end
				S_PUT: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (resp_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers. Get walks its single entry; pop walks up from the
	// position to the last entry, moving each one down; insert walks down from
	// the last entry to the position, moving each one up. The first entry read
	// by get and pop is captured as the result instead of being written back.
	always_ff @(posedge clk) begin
		if (accept) begin
			rv_q    <= '0;
			value_q <= value[VALUE_WIDTH-1:0];
			pos_q   <= (opcode == OP_APPEND) ? AW'(count_q) : pos_a;
			cur_q   <= (opcode == OP_INSERT) ? last_a : pos_a;
			end_q   <= (opcode == OP_POP) ? last_a : pos_a;
		end
		if (state_q == S_WALK) begin
			cur_q  <= up_q ? (cur_q + AW'(1)) : (cur_q - AW'(1));
			wa_s1  <= up_q ? (cur_q - AW'(1)) : (cur_q + AW'(1));
			cap_s1 <= first_q;
		end
		if (pend_s1 && cap_s1) begin
			rv_q <= rdata_s1;
		end
		if (resp_go) begin
			read_value  <= VALUE_W'(rv_q);
			status      <= st_q;
			entry_count <= COUNT_W'(count_q);
		end
	end

	`ILS_ASSERT_NOW(a_idle_no_write, clk, arst_n, state_q == S_IDLE, !mem_we,
		"memory written while idle")
	`ILS_ASSERT_NOW(a_put_after_drain, clk, arst_n, state_q == S_PUT, !pend_s1,
		"new value collides with a pending shifted entry")
	`ILS_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(CAPACITY),
		"entry count above capacity")
	`ILS_ASSERT_NOW(a_error_no_work, clk, arst_n,
		(st_q != ST_OK) && (state_q != S_IDLE), state_q == S_RESP,
		"failed operation touched the memory")

endmodule
